// File: src/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
// No dependencies; imported by sfs_divider, the top level and the testbench.
package sfs_pkg;

  localparam int ROW_TABLE_DEPTH_DEF  = 64;
  localparam int FRAME_INDEX_BITS_DEF = 12;

  // field widths of the stream items
  localparam int FT_W       = 24;
  localparam int SIZE_W     = 13;
  localparam int IDX_W      = 13;
  localparam int ROW_W      = 6;
  localparam int ROWF_W     = 12;
  localparam int UV_W       = 17;
  localparam int IN_TDATA_W = 72;
  localparam int CFG_ADDR_W = 5;

  localparam logic [UV_W-1:0] Q16_ONE = 17'h10000;

  // register reset values
  localparam logic [FT_W-1:0]   FRAME_TIME_RST   = 24'd100000;
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd32;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd32;
  localparam logic [SIZE_W-1:0] SHEET_WIDTH_RST  = 13'd256;
  localparam logic [SIZE_W-1:0] SHEET_HEIGHT_RST = 13'd256;

  // serial divider operand widths
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 24;

  typedef enum logic [2:0] {
    REG_FRAME_TIME   = 3'd0,
    REG_FRAME_WIDTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_SHEET_WIDTH  = 3'd3,
    REG_SHEET_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_WINDOW = 2'd1,
    CMD_SET_ROW    = 2'd2,
    CMD_LOAD_ROW   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

endpackage

// File: src/sfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/sfs_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sfs_pkg (operand widths, request struct).
module sfs_divider import sfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  output logic [DIV_NUM_W-1:0] quotient_o,
  output logic [DIV_DEN_W-1:0] remainder_o,
  output logic                 done_o
);

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_DEN_W:0]   trial, diff;
  logic                 ge;

  // shift next dividend bit into the partial remainder, try subtract
  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
      rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

// File: src/sprite_frame_sequencer.sv
// Sprite-sheet animation sequencer: top level with register port and control sequencer.
// Depends on sfs_pkg, sfs_divider and sfs_ram.
//
// Takes one request at a time on the slave stream and returns one result per request:
// the absolute frame on show and its UV rectangle in Q1.16 (65536 is 1.0), plus a flag
// for a set-row request that named a row outside the sheet. Commands (tuser): tick
// advances time, set window picks a frame range, set row picks a row range through the
// row frame-count table, load writes that table. All divisions (sheet columns and rows,
// time to frames, frame wrap, frame to column/row, four UV fractions) run one after
// another on a single bit-serial divider. A tick with no saturated UV edge is the
// longest request, at about 9 divisions. The result waits in an output register, so
// the next request is taken as soon as the sequencer is back in idle. The user must
// write configuration through the APB port only while no request is in flight; the
// block itself does not enforce this. The row table is a RAM with no reset; reading
// a row that was never loaded gives an undefined count.
module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int ROW_TABLE_DEPTH  = ROW_TABLE_DEPTH_DEF,
  parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEF,
  parameter int OUT_W = ((FRAME_INDEX_BITS + 4 * UV_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: elapsed[23:0], start_index[36:24], span[49:37], row_number[55:50],
  //        row_frames[67:56], zero fill
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: command[1:0]
  input  logic [1:0]            s_axis_tuser_i,
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: frame_index[11:0], u_left[28:12], v_top[45:29], u_right[62:46],
  //        v_bottom[79:63]
  output logic [OUT_W-1:0]      m_axis_tdata_o,
  // tuser: row_rejected
  output logic                  m_axis_tuser_o,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int FIB = FRAME_INDEX_BITS;
  localparam int TW  = FIB + 1;                  // frame count up to 2^FIB
  localparam int AW  = (ROW_TABLE_DEPTH > 1) ? $clog2(ROW_TABLE_DEPTH) : 1;
  localparam int UW  = $clog2(ROW_TABLE_DEPTH + 1);
  localparam int TXW = FIB + 1 + SIZE_W;         // texel coordinate
  localparam int SW  = 24;                       // signed window arithmetic

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_WAIT  = 15'b000000000000010,
    S_COLS  = 15'b000000000000100,
    S_ROWS  = 15'b000000000001000,
    S_TOTAL = 15'b000000000010000,
    S_DISP  = 15'b000000000100000,
    S_TICK1 = 15'b000000001000000,
    S_TICK2 = 15'b000000010000000,
    S_ROWRD = 15'b000000100000000,
    S_ROWAP = 15'b000001000000000,
    S_ABS   = 15'b000010000000000,
    S_UV    = 15'b000100000000000,
    S_QS    = 15'b001000000000000,
    S_QD    = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  // ---------------- configuration registers ----------------
  logic [FT_W-1:0]   ft_q;
  logic [SIZE_W-1:0] fw_q, fh_q, sw_q, sh_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q <= FRAME_TIME_RST;
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
      sw_q <= SHEET_WIDTH_RST;
      sh_q <= SHEET_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_FRAME_TIME:   ft_q <= pwdata[FT_W-1:0];
        REG_FRAME_WIDTH:  fw_q <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= pwdata[SIZE_W-1:0];
        REG_SHEET_WIDTH:  sw_q <= pwdata[SIZE_W-1:0];
        REG_SHEET_HEIGHT: sh_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_FRAME_TIME:   prdata = 32'(ft_q);
      REG_FRAME_WIDTH:  prdata = 32'(fw_q);
      REG_FRAME_HEIGHT: prdata = 32'(fh_q);
      REG_SHEET_WIDTH:  prdata = 32'(sw_q);
      REG_SHEET_HEIGHT: prdata = 32'(sh_q);
      default:          prdata = '0;
    endcase
  end

  // zero registers count as one
  logic [FT_W-1:0]   ft1;
  logic [SIZE_W-1:0] fw1, fh1, sw1, sh1;
  assign ft1 = (ft_q == '0) ? FT_W'(1) : ft_q;
  assign fw1 = (fw_q == '0) ? SIZE_W'(1) : fw_q;
  assign fh1 = (fh_q == '0) ? SIZE_W'(1) : fh_q;
  assign sw1 = (sw_q == '0) ? SIZE_W'(1) : sw_q;
  assign sh1 = (sh_q == '0) ? SIZE_W'(1) : sh_q;

  // ---------------- state ----------------
  state_e                  state_q, state_d, ret_q, ret_d;
  cmd_e                    cmd_q;
  logic [FT_W-1:0]         elapsed_q;
  logic signed [IDX_W-1:0] start_q, span_q;
  logic [ROW_W-1:0]        row_q;
  logic [ROWF_W-1:0]       rowf_q;

  logic [SIZE_W-1:0]     cols_q, cols_d, rows_q, rows_d;
  logic [2*SIZE_W-1:0]   traw_q, traw_d;
  logic [TW-1:0]         total_q, total_d;
  logic [FT_W-1:0]       tacc_q, tacc_d;
  logic [FIB-1:0]        local_q, local_d, wf_q, wf_d, abs_q, abs_d;
  logic [TW-1:0]         wl_q, wl_d;
  logic [UW-1:0]         used_q, used_d;
  logic                  rej_q, rej_d;
  logic signed [SW-1:0]  rs_start_q, rs_start_d, rs_span_q, rs_span_d;
  logic [TXW-1:0]        tx_q [4];
  logic [TXW-1:0]        tx_d [4];
  logic [UV_W-1:0]       uv_q [4];
  logic [UV_W-1:0]       uv_d [4];
  logic [1:0]            k_q, k_d;
  logic                  out_valid_q, out_valid_d, out_rej_q, out_rej_d;
  logic [OUT_W-1:0]      out_data_q, out_data_d;

  logic                  accept;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // ---------------- divider and row table ----------------
  div_req_t              div_req;
  logic [DIV_NUM_W-1:0]  div_quo;
  logic [DIV_DEN_W-1:0]  div_rem;
  logic                  div_done;

  sfs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .done_o     (div_done)
  );

  logic [7:0]        row8;
  logic              ram_we;
  logic [ROWF_W-1:0] ram_rdata;
  assign row8 = 8'(row_q);

  sfs_ram #(
    .WIDTH(ROWF_W),
    .DEPTH(ROW_TABLE_DEPTH),
    .AW   (AW)
  ) u_row_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(row8[AW-1:0]),
    .wdata_i(rowf_q),
    .raddr_i(row8[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // ---------------- window clamp ----------------
  logic signed [SW-1:0] aw_in_start, aw_in_count, aw_st, aw_cn, tot_s;
  logic [FIB-1:0]       aw_first;
  logic [TW-1:0]        aw_len;

  always_comb begin
    tot_s       = $signed(SW'(total_q));
    aw_in_start = (state_q == S_ROWAP) ? rs_start_q
                                       : $signed({{(SW-IDX_W){start_q[IDX_W-1]}}, start_q});
    aw_in_count = (state_q == S_ROWAP) ? rs_span_q
                                       : $signed({{(SW-IDX_W){span_q[IDX_W-1]}}, span_q});
    aw_st = aw_in_start;
    if (aw_st < 0) aw_st = '0;
    if (aw_st >= tot_s) aw_st = tot_s - 1;
    aw_cn = aw_in_count;
    if (aw_cn <= 0) aw_cn = SW'(1);
    if (aw_st + aw_cn > tot_s) aw_cn = tot_s - aw_st;
    aw_first = aw_st[FIB-1:0];
    aw_len   = aw_cn[TW-1:0];
  end

  // ---------------- set-row clamp ----------------
  logic                 use_tab;
  logic signed [SW-1:0] avail, r_st, r_sp, maxc;
  logic [ROW_W+SIZE_W-1:0] rprod;

  always_comb begin
    use_tab = 9'(row_q) < 9'(used_q);
    avail   = use_tab ? $signed(SW'(ram_rdata)) : $signed(SW'(cols_q));
    r_st    = $signed({{(SW-IDX_W){start_q[IDX_W-1]}}, start_q});
    if (r_st >= avail) r_st = avail - 1;
    maxc = avail - r_st;
    r_sp = $signed({{(SW-IDX_W){span_q[IDX_W-1]}}, span_q});
    if (r_sp < 0 || r_sp > maxc) r_sp = maxc;
    rprod = (ROW_W+SIZE_W)'(row_q) * (ROW_W+SIZE_W)'(cols_q);
  end

  // ---------------- sequencer ----------------
  logic [FT_W:0]     acc;
  logic [TW-1:0]     efflen;
  logic [FIB-1:0]    col, rw;
  logic [SIZE_W-1:0] size_k;
  logic              sat_k;

  assign acc    = (FT_W+1)'(tacc_q) + (FT_W+1)'(elapsed_q);
  assign efflen = (wl_q != '0) ? wl_q : total_q;
  assign col    = div_rem[FIB-1:0];
  assign rw     = div_quo[FIB-1:0];
  assign size_k = k_q[0] ? sh1 : sw1;
  assign sat_k  = tx_q[k_q] >= TXW'(size_k);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cols_d      = cols_q;
    rows_d      = rows_q;
    traw_d      = traw_q;
    total_d     = total_q;
    tacc_d      = tacc_q;
    local_d     = local_q;
    wf_d        = wf_q;
    wl_d        = wl_q;
    used_d      = used_q;
    rej_d       = rej_q;
    rs_start_d  = rs_start_q;
    rs_span_d   = rs_span_q;
    abs_d       = abs_q;
    tx_d        = tx_q;
    uv_d        = uv_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_rej_d   = out_rej_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    div_req     = '0;

    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rej_d            = 1'b0;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'(sw1);
          div_req.divisor  = DIV_DEN_W'(fw1);
          ret_d            = S_COLS;
          state_d          = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_done) state_d = ret_q;
      end
      S_COLS: begin
        cols_d           = (div_quo == '0) ? SIZE_W'(1) : div_quo[SIZE_W-1:0];
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'(sh1);
        div_req.divisor  = DIV_DEN_W'(fh1);
        ret_d            = S_ROWS;
        state_d          = S_WAIT;
      end
      S_ROWS: begin
        rows_d  = (div_quo == '0) ? SIZE_W'(1) : div_quo[SIZE_W-1:0];
        traw_d  = (2*SIZE_W)'(cols_q) * (2*SIZE_W)'(rows_d);
        state_d = S_TOTAL;
      end
      S_TOTAL: begin
        // cap at 2^FIB frames
        total_d = (traw_q > (2*SIZE_W)'(1 << FIB)) ? TW'(1 << FIB) : traw_q[TW-1:0];
        state_d = S_DISP;
      end
      S_DISP: begin
        unique case (cmd_q)
          CMD_TICK: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_W'(acc);
            div_req.divisor  = DIV_DEN_W'(ft1);
            ret_d            = S_TICK1;
            state_d          = S_WAIT;
          end
          CMD_SET_WINDOW: begin
            wf_d    = aw_first;
            wl_d    = aw_len;
            local_d = '0;
            state_d = S_ABS;
          end
          CMD_SET_ROW: begin
            if (SIZE_W'(row_q) >= rows_q) begin
              rej_d   = 1'b1;
              state_d = S_ABS;
            end else begin
              state_d = S_ROWRD;   // table read data arrives next cycle
            end
          end
          CMD_LOAD_ROW: begin
            if (9'(row_q) < 9'(ROW_TABLE_DEPTH)) begin
              ram_we = 1'b1;
              if (9'(row_q) + 9'd1 > 9'(used_q)) used_d = UW'(9'(row_q) + 9'd1);
            end
            state_d = S_ABS;
          end
          default: state_d = S_ABS;
        endcase
      end
      S_TICK1: begin
        tacc_d           = div_rem[FT_W-1:0];
        div_req.start    = 1'b1;
        div_req.dividend = div_quo + DIV_NUM_W'(local_q);
        div_req.divisor  = DIV_DEN_W'(efflen);
        ret_d            = S_TICK2;
        state_d          = S_WAIT;
      end
      S_TICK2: begin
        local_d = div_rem[FIB-1:0];
        state_d = S_ABS;
      end
      S_ROWRD: begin
        rs_start_d = $signed(SW'(rprod)) + r_st;
        rs_span_d  = r_sp;
        state_d    = S_ROWAP;
      end
      S_ROWAP: begin
        wf_d    = aw_first;
        wl_d    = aw_len;
        local_d = '0;
        state_d = S_ABS;
      end
      S_ABS: begin
        abs_d            = wf_q + local_q;
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'(abs_d);
        div_req.divisor  = DIV_DEN_W'(cols_q);
        ret_d            = S_UV;
        state_d          = S_WAIT;
      end
      S_UV: begin
        tx_d[0] = TXW'(col) * TXW'(fw1);
        tx_d[1] = TXW'(rw) * TXW'(fh1);
        tx_d[2] = (TXW'(col) + TXW'(1)) * TXW'(fw1);
        tx_d[3] = (TXW'(rw) + TXW'(1)) * TXW'(fh1);
        k_d     = '0;
        state_d = S_QS;
      end
      S_QS: begin
        if (sat_k) begin
          // edge at or past the sheet border
          uv_d[k_q] = Q16_ONE;
          k_d       = k_q + 2'd1;
          state_d   = (k_q == 2'd3) ? S_DONE : S_QS;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'({tx_q[k_q][SIZE_W-1:0], 16'b0});
          div_req.divisor  = DIV_DEN_W'(size_k);
          ret_d            = S_QD;
          state_d          = S_WAIT;
        end
      end
      S_QD: begin
        uv_d[k_q] = div_quo[UV_W-1:0];
        k_d       = k_q + 2'd1;
        state_d   = (k_q == 2'd3) ? S_DONE : S_QS;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_rej_d   = rej_q;
          out_data_d  = OUT_W'({uv_q[3], uv_q[2], uv_q[1], uv_q[0], abs_q});
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      tacc_q      <= '0;
      local_q     <= '0;
      wf_q        <= '0;
      wl_q        <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      tacc_q      <= tacc_d;
      local_q     <= local_d;
      wf_q        <= wf_d;
      wl_q        <= wl_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_e'(s_axis_tuser_i);
      elapsed_q <= s_axis_tdata_i[23:0];
      start_q   <= $signed(s_axis_tdata_i[36:24]);
      span_q    <= $signed(s_axis_tdata_i[49:37]);
      row_q     <= s_axis_tdata_i[55:50];
      rowf_q    <= s_axis_tdata_i[67:56];
    end
    cols_q     <= cols_d;
    rows_q     <= rows_d;
    traw_q     <= traw_d;
    total_q    <= total_d;
    rej_q      <= rej_d;
    rs_start_q <= rs_start_d;
    rs_span_q  <= rs_span_d;
    abs_q      <= abs_d;
    tx_q       <= tx_d;
    uv_q       <= uv_d;
    k_q        <= k_d;
    out_rej_q  <= out_rej_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_rej_q;

  // ---------------- checks ----------------
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after a request");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_WAIT)
    else $error("divider finished outside wait state");

  a_div_start_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> state_q == S_WAIT)
    else $error("divider started without waiting for it");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= ROW_TABLE_DEPTH)
    else $error("row table fill count past depth");

endmodule

// File: tb/sfs_checker.sv
// Scoreboard for the sprite frame sequencer: snoops the register port and both streams,
// predicts each result and compares it field by field. Depends on sfs_pkg.
module sfs_checker import sfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [IN_TDATA_W-1:0] s_data_i,
  input  logic [1:0]            s_user_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [79:0]           m_data_i,
  input  logic                  m_user_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]           pwdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0]     frame;
    logic [UV_W-1:0] u_l;
    logic [UV_W-1:0] v_t;
    logic [UV_W-1:0] u_r;
    logic [UV_W-1:0] v_b;
    logic            rej;
  } frame_rect_t;

  frame_rect_t rect_q[$];
  int          fails;

  logic [FT_W-1:0]   ft_r;
  logic [SIZE_W-1:0] fw_r, fh_r, sw_r, sh_r;
  logic [24:0]       acc_r;
  logic [11:0]       local_r, first_r;
  logic [12:0]       len_r;
  logic [11:0]       rowtab[64];
  logic [6:0]        used_r;

  function automatic longint nz(longint v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic longint n_cols();
    return nz(nz(sw_r) / nz(fw_r));
  endfunction

  function automatic longint n_rows();
    return nz(nz(sh_r) / nz(fh_r));
  endfunction

  function automatic longint n_total();
    longint t;
    t = n_cols() * n_rows();
    return (t > 4096) ? 4096 : t;
  endfunction

  function automatic logic [UV_W-1:0] frac16(longint texel, longint size);
    longint q;
    q = (texel << 16) / nz(size);
    return (q > 65536) ? Q16_ONE : UV_W'(q);
  endfunction

  task automatic set_window(longint st, longint cnt);
    longint tot;
    tot = n_total();
    if (st < 0) st = 0;
    if (st >= tot) st = tot - 1;
    if (cnt <= 0) cnt = 1;
    if (st + cnt > tot) cnt = tot - st;
    first_r = 12'(st);
    len_r   = 13'(cnt);
    local_r = '0;
  endtask

  // advance the sequencer by one request and return the rectangle on show
  task automatic predict_rect(input logic [IN_TDATA_W-1:0] d, input cmd_e cmd,
                              output frame_rect_t r);
    longint elapsed, st, sp, row, frames, acc, steps, len, cols, avail, maxc, absf;
    longint col, rw;
    elapsed = d[23:0];
    st      = longint'($signed(d[36:24]));
    sp      = longint'($signed(d[49:37]));
    row     = d[55:50];
    frames  = d[67:56];
    r.rej   = 1'b0;
    case (cmd)
      CMD_TICK: begin
        acc     = acc_r + elapsed;
        steps   = acc / nz(ft_r);
        acc_r   = 25'(acc % nz(ft_r));
        len     = nz((len_r != 0) ? len_r : n_total());
        local_r = 12'((local_r + steps) % len);
      end
      CMD_SET_WINDOW: set_window(st, sp);
      CMD_SET_ROW: begin
        if (row >= n_rows()) begin
          r.rej = 1'b1;
        end else begin
          cols  = n_cols();
          avail = (row < used_r) ? longint'(rowtab[row]) : cols;
          if (st >= avail) st = avail - 1;
          maxc = avail - st;
          if (sp < 0 || sp > maxc) sp = maxc;
          set_window(row * cols + st, sp);
        end
      end
      default: begin
        rowtab[row] = 12'(frames);
        if (row + 1 > used_r) used_r = 7'(row + 1);
      end
    endcase
    absf    = (first_r + local_r) & 12'hFFF;
    cols    = n_cols();
    col     = absf % cols;
    rw      = absf / cols;
    r.frame = 12'(absf);
    r.u_l   = frac16(col * nz(fw_r), sw_r);
    r.v_t   = frac16(rw * nz(fh_r), sh_r);
    r.u_r   = frac16((col + 1) * nz(fw_r), sw_r);
    r.v_b   = frac16((rw + 1) * nz(fh_r), sh_r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_rect_t want, got;
    if (!rst_ni) begin
      ft_r    = FRAME_TIME_RST;
      fw_r    = FRAME_WIDTH_RST;
      fh_r    = FRAME_HEIGHT_RST;
      sw_r    = SHEET_WIDTH_RST;
      sh_r    = SHEET_HEIGHT_RST;
      acc_r   = '0;
      local_r = '0;
      first_r = '0;
      len_r   = '0;
      used_r  = '0;
      fails   = 0;
      rect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_reg_e'(paddr_i[4:2]))
          REG_FRAME_TIME:   ft_r = pwdata_i[FT_W-1:0];
          REG_FRAME_WIDTH:  fw_r = pwdata_i[SIZE_W-1:0];
          REG_FRAME_HEIGHT: fh_r = pwdata_i[SIZE_W-1:0];
          REG_SHEET_WIDTH:  sw_r = pwdata_i[SIZE_W-1:0];
          REG_SHEET_HEIGHT: sh_r = pwdata_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      // result side first: a result still parked may leave as the next request enters
      if (m_valid_i && m_ready_i) begin
        got = {m_data_i[11:0], m_data_i[28:12], m_data_i[45:29], m_data_i[62:46],
               m_data_i[79:63], m_user_i};
        if (rect_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%t: result with nothing expected: %h", $realtime, got);
        end else begin
          want = rect_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display({"%t: mismatch frame %0d/%0d uL %0d/%0d vT %0d/%0d uR %0d/%0d",
                        " vB %0d/%0d rej %0d/%0d (exp/act)"},
                       $realtime, want.frame, got.frame, want.u_l, got.u_l, want.v_t, got.v_t,
                       want.u_r, got.u_r, want.v_b, got.v_b, want.rej, got.rej);
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        predict_rect(s_data_i, cmd_e'(s_user_i), want);
        rect_q.push_back(want);
      end
      fail_count_o <= fails;
      pending_o    <= rect_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the sprite frame sequencer testbench: clock, reset, stimulus and verdict.
// Depends on sfs_pkg, sprite_frame_sequencer and sfs_checker.
module tb_top;
  import sfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 20000;  // cycles with no traffic at all
  localparam int N_PHASE    = 6;
  localparam int PHASE_REQS = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_TDATA_W-1:0] s_data = '0;
  logic [1:0]            s_user = CMD_TICK;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [79:0]           m_data;
  logic                  m_user;
  logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  int                    fail_count, pending;

  // idle percentages per side, changed per phase
  int src_idle = 6;
  int snk_idle = 61;

  // mirror of the register settings, used to shape stimulus
  int ft_cfg = 100000;
  int rows_cfg = 8;
  int table_fill = 0;   // rows loaded so far, always contiguous from row 0

  int  wdog;

  always #5 clk_i = ~clk_i;

  sprite_frame_sequencer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data),   .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data),   .m_axis_tuser_o(m_user),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sfs_checker u_chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side back-pressure
  always @(posedge clk_i) m_ready <= ($urandom_range(0, 99) >= snk_idle);

  // stall watchdog: any handshake on either stream or the register port resets it
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("sprite_frame_sequencer verification failed");
        $finish;
      end
    end
  end

  // one request; valid stays up across back-to-back requests
  task automatic send_req(cmd_e cmd, int elapsed, int st, int sp, int row, int frames);
    if ($urandom_range(0, 99) < src_idle) begin
      s_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {4'b0, 12'(frames), 6'(row), 13'(sp), 13'(st), 24'(elapsed)};
    do @(posedge clk_i); while (!s_ready);
    if (cmd == CMD_LOAD_ROW && row == table_fill) table_fill++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
  endtask

  // all five registers, each with a setup phase then an access phase
  task automatic write_regs(int ft, int fw, int fh, int sw, int sh);
    int vals[5];
    vals = '{ft, fw, fh, sw, sh};
    for (int i = 0; i < 5; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CFG_ADDR_W'(4 * i);
      pwdata  <= vals[i];
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    ft_cfg   = ft;
    rows_cfg = sh / fh;
    if (rows_cfg == 0) rows_cfg = 1;
  endtask

  task automatic random_req();
    int pick, elapsed, st, sp, row;
    pick    = $urandom_range(0, 99);
    elapsed = $urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF)
                                   : $urandom_range(0, (ft_cfg < 5000000) ? 3 * ft_cfg : ft_cfg);
    st      = $urandom_range(0, 2) ? $urandom_range(0, 20) : $urandom_range(0, 8191);
    case ($urandom_range(0, 3))
      0: sp = 8191;                        // all of the row
      1: sp = $urandom_range(0, 8191);
      default: sp = $urandom_range(0, 12);
    endcase
    // rows mostly inside the sheet, some beyond it
    row = $urandom_range(0, 3) ? $urandom_range(0, (rows_cfg < 64 ? rows_cfg : 64) - 1)
                               : $urandom_range(0, 63);
    if (pick < 45) begin
      send_req(CMD_TICK, elapsed, st, sp, row, $urandom_range(0, 4095));
    end else if (pick < 60) begin
      send_req(CMD_SET_WINDOW, elapsed, st, sp, row, $urandom_range(0, 4095));
    end else if (pick < 85) begin
      send_req(CMD_SET_ROW, elapsed, st, sp, row, $urandom_range(0, 4095));
    end else begin
      // loads never skip a row, so no set row ever reads an unloaded entry
      if (table_fill < 64 && $urandom_range(0, 1)) row = table_fill;
      else row = $urandom_range(0, (table_fill < 64) ? table_fill : 63);
      send_req(CMD_LOAD_ROW, elapsed, st, sp, row,
               $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 40));
    end
  endtask

  initial begin
    int cfg[N_PHASE][5];
    cfg = '{'{100000, 32, 32, 256, 256},
            '{1, 1, 1, 4096, 4096},                 // finest grid, frame count capped
            '{16777215, 4096, 4096, 1, 1},          // frame larger than sheet
            '{7, 3, 5, 100, 90},
            '{1000, 64, 1, 4096, 64},
            '{250, 13, 7, 4095, 4095}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, window and row clamping, table lookups, bad rows
    send_req(CMD_TICK, 0, 0, 0, 0, 0);
    send_req(CMD_TICK, 24'hFFFFFF, 0, 0, 0, 0);
    send_req(CMD_TICK, 99999, 0, 0, 0, 0);
    send_req(CMD_TICK, 1, 0, 0, 0, 0);
    send_req(CMD_SET_WINDOW, 0, -4096, -4096, 0, 0);
    send_req(CMD_SET_WINDOW, 0, 4095, 4095, 0, 0);
    send_req(CMD_SET_WINDOW, 0, 5, -1, 0, 0);
    send_req(CMD_SET_WINDOW, 0, 3, 0, 0, 0);
    send_req(CMD_SET_WINDOW, 0, 10, 20, 0, 0);
    send_req(CMD_TICK, 250000, 0, 0, 0, 0);
    send_req(CMD_LOAD_ROW, 0, 0, 0, 0, 3);
    send_req(CMD_LOAD_ROW, 0, 0, 0, 1, 4095);
    send_req(CMD_LOAD_ROW, 0, 0, 0, 2, 0);          // empty row
    send_req(CMD_SET_ROW, 0, 1, -1, 0, 0);
    send_req(CMD_SET_ROW, 0, -5, 4095, 1, 0);
    send_req(CMD_SET_ROW, 0, 0, 2, 2, 0);
    send_req(CMD_SET_ROW, 0, 100, 3, 3, 0);         // not in table: the sheet's column count is used
    send_req(CMD_SET_ROW, 0, 0, 1, 8, 0);           // first row past the sheet
    send_req(CMD_SET_ROW, 0, 0, 1, 63, 0);
    send_req(CMD_TICK, 100000, 0, 0, 0, 0);

    for (int p = 0; p < N_PHASE; p++) begin
      if (p >= 2) begin
        src_idle = (p < 4) ? 61 : 0;
        snk_idle = (p < 4) ? 6 : 0;
      end
      if (p > 0) begin
        drain();
        write_regs(cfg[p][0], cfg[p][1], cfg[p][2], cfg[p][3], cfg[p][4]);
        // a stale window from the previous sheet carries over into this one
        send_req(CMD_TICK, 0, 0, 0, 0, 0);
      end
      for (int i = 0; i < PHASE_REQS; i++) random_req();
    end
    drain();
    // go back to reset values so that every register sees its default once more
    write_regs(100000, 32, 32, 256, 256);
    for (int i = 0; i < 20; i++) random_req();

    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) $display("sprite_frame_sequencer verification clean");
    else $display("sprite_frame_sequencer verification failed");
    $finish;
  end

endmodule

// File: sim.f
src/sfs_pkg.sv
src/sfs_ram.sv
src/sfs_divider.sv
src/sprite_frame_sequencer.sv
tb/sfs_checker.sv
tb/tb_top.sv
